/* sv/tcw_pkg.sv */
// Shared command codes, character codes, register indexes and widths for the console writer.
package tcw_pkg;

  localparam int LIN_W = 15;

  localparam logic [2:0] CMD_PUT   = 3'd0;
  localparam logic [2:0] CMD_SET   = 3'd1;
  localparam logic [2:0] CMD_CLS   = 3'd2;
  localparam logic [2:0] CMD_CLL   = 3'd3;
  localparam logic [2:0] CMD_INS   = 3'd4;
  localparam logic [2:0] CMD_DEL   = 3'd5;
  localparam logic [2:0] CMD_READ  = 3'd6;

  localparam logic [1:0] CLR_TO_END   = 2'd0;
  localparam logic [1:0] CLR_TO_CUR   = 2'd1;
  localparam logic [1:0] CLR_WHOLE    = 2'd2;
  localparam logic [1:0] CLR_NONE     = 2'd3;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_BLANK = 8'h20;

  localparam logic [2:0] REG_RES    = 3'd0;
  localparam logic [2:0] REG_DOUBLE = 3'd1;
  localparam logic [2:0] REG_BORDER = 3'd2;
  localparam logic [2:0] REG_BW     = 3'd3;
  localparam logic [2:0] REG_BH     = 3'd4;
  localparam logic [2:0] REG_FG     = 3'd5;
  localparam logic [2:0] REG_BG     = 3'd6;

  typedef enum logic [1:0] {W_FILL, W_COPY, W_READ} walk_t;

endpackage

/* sv/text_console_cell_writer.sv */
// Text console writer: cursor control, one character/color memory and a cell walker.
// Return, or backspace at column 0, only reports; a cursor move places the cursor; a read fetches
// one cell; a printable writes its cell, then moves; a backspace moves, then blanks the cell; a line
// clear fills cells; insert/delete shifts the line and blanks a cell; clear screen fills the store;
// a scroll copies rows up and blanks the last. One command at a time; a held result delays the next.
// Synchronous reset homes the cursor and restores register defaults; the memory is not cleared.
module text_console_cell_writer #(
  parameter int CELL_COUNT = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [7:0]  char_code,
  input  logic [6:0]  pos_x,
  input  logic [6:0]  pos_y,
  input  logic [1:0]  clear_mode,
  input  logic [13:0] cell_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  cursor_col,
  output logic [6:0]  cursor_row,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_color,
  output logic        did_scroll,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import tcw_pkg::*;

  localparam int AW = $clog2(CELL_COUNT);
  localparam logic [LIN_W-1:0] CC = LIN_W'(CELL_COUNT);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_PLAN, S_SMUL, S_SLAUNCH, S_WRAP, S_WALK, S_CPW, S_POST, S_DONE
  } state_t;

  typedef enum logic [1:0] {A_DONE, A_PLACE, A_WALK} act_t;

  state_t st;

  // configuration
  logic [1:0] res_sel;
  logic       pix_dbl;
  logic       brd_en;
  logic [7:0] brd_w;
  logic [7:0] brd_h;
  logic [3:0] fg;
  logic [3:0] bg;

  // command
  logic [2:0]  cmd_q;
  logic [7:0]  ch_q;
  logic [6:0]  px_q;
  logic [6:0]  py_q;
  logic [1:0]  mode_q;
  logic [13:0] idx_q;

  logic [6:0] cur_col;
  logic [6:0] cur_row;
  logic [1:0] phase;
  logic [1:0] scr;
  logic       scrolled;
  logic [7:0] rd_char;
  logic [7:0] rd_color;
  logic [LIN_W-1:0] sol;
  logic [LIN_W-1:0] sprod;

  // walker
  walk_t            wk;
  logic             up;
  logic [LIN_W-1:0] dst;
  logic [LIN_W-1:0] src;
  logic [LIN_W-1:0] cnt;
  logic [15:0]      wdata;

  logic [15:0] mem [CELL_COUNT];
  logic [15:0] rdata;
  logic        mem_we;
  logic [15:0] mem_wd;

  // output register
  logic [6:0] o_col;
  logic [6:0] o_row;
  logic [7:0] o_char;
  logic [7:0] o_color;
  logic       o_scr;

  logic [7:0] cm;
  logic [7:0] rm;
  logic [7:0] vc;
  logic [7:0] vr;
  logic [7:0] color;

  function automatic logic [7:0] visible(input logic [7:0] full, input logic [7:0] px,
                                         input logic en, input logic dbl);
    logic [7:0] red;
    red = en ? (dbl ? (px >> 3) : (px >> 2)) : 8'd0;
    return (full > red + 8'd1) ? full - red : 8'd1;
  endfunction

  function automatic logic [LIN_W-1:0] step(input logic [LIN_W-1:0] a, input logic dir_up);
    if (dir_up) return (a == CC - LIN_W'(1)) ? '0 : a + LIN_W'(1);
    else        return (a == '0) ? CC - LIN_W'(1) : a - LIN_W'(1);
  endfunction

  always_comb begin
    unique case (res_sel)
      2'd1:    begin cm = 8'd100; rm = 8'd75; end
      2'd2:    begin cm = 8'd128; rm = 8'd96; end
      2'd3:    begin cm = 8'd80;  rm = 8'd50; end
      default: begin cm = 8'd80;  rm = 8'd60; end
    endcase
    if (pix_dbl) begin
      cm = cm >> 1;
      rm = rm >> 1;
    end
  end

  assign vc    = visible(cm, brd_w, brd_en, pix_dbl);
  assign vr    = visible(rm, brd_h, brd_en, pix_dbl);
  assign color = {fg, bg};

  // cursor placement target and result
  logic [7:0] tx;
  logic [7:0] ty;
  logic [7:0] ny1;
  logic [6:0] nx;
  logic [6:0] ny;
  logic       nscroll;

  always_comb begin
    tx = {1'b0, cur_col} + 8'd1;
    ty = {1'b0, cur_row};
    if (cmd_q == CMD_SET) begin
      tx = {1'b0, px_q};
      ty = {1'b0, py_q};
    end else if (ch_q == CH_LF) begin
      tx = 8'd0;
      ty = {1'b0, cur_row} + 8'd1;
    end else if (ch_q == CH_BS) begin
      tx = {1'b0, cur_col} - 8'd1;
    end else if (ch_q == CH_TAB) begin
      tx = {1'b0, cur_col} + 8'd8;
    end
    nx  = (tx >= vc) ? 7'd0 : tx[6:0];
    ny1 = (tx >= vc) ? ty + 8'd1 : ty;
    nscroll = (ny1 >= vr);
    ny  = nscroll ? 7'(vr - 8'd1) : ny1[6:0];
  end

  // plan for the current command phase
  logic [LIN_W-1:0] cur_lin;
  logic [LIN_W-1:0] last_lin;
  logic [LIN_W-1:0] span;
  act_t             p_act;
  walk_t            p_wk;
  logic             p_up;
  logic [LIN_W-1:0] p_dst;
  logic [LIN_W-1:0] p_src;
  logic [LIN_W-1:0] p_cnt;
  logic [15:0]      p_wd;

  assign cur_lin  = sol + LIN_W'(cur_col);
  assign last_lin = sol + LIN_W'(cm) - LIN_W'(1);
  assign span     = (last_lin > cur_lin) ? last_lin - cur_lin : '0;

  always_comb begin
    p_act = A_DONE;
    p_wk  = W_FILL;
    p_up  = 1'b1;
    p_dst = cur_lin;
    p_src = cur_lin;
    p_cnt = LIN_W'(1);
    p_wd  = {CH_BLANK, color};
    unique case (cmd_q)
      CMD_PUT: begin
        priority if (ch_q == CH_CR) begin
          p_act = A_DONE;
        end else if (ch_q == CH_LF || ch_q == CH_TAB) begin
          if (phase == 2'd0) p_act = A_PLACE;
        end else if (ch_q == CH_BS) begin
          if (phase == 2'd0 && cur_col != 7'd0) p_act = A_PLACE;
          else if (phase == 2'd1) p_act = A_WALK;
        end else begin
          if (phase == 2'd0) begin
            p_act = A_WALK;
            p_wd  = {ch_q, color};
          end else if (phase == 2'd1) begin
            p_act = A_PLACE;
          end
        end
      end
      CMD_SET: if (phase == 2'd0) p_act = A_PLACE;
      CMD_CLS: begin
        if (phase == 2'd0) begin
          p_act = A_WALK;
          p_dst = '0;
          p_cnt = CC;
        end
      end
      CMD_CLL: begin
        if (phase == 2'd0) begin
          p_act = A_WALK;
          unique case (mode_q)
            CLR_TO_END: p_cnt = (cur_lin <= last_lin) ? last_lin - cur_lin + LIN_W'(1) : '0;
            CLR_TO_CUR: begin
              p_dst = sol;
              p_cnt = LIN_W'(cur_col) + LIN_W'(1);
            end
            CLR_WHOLE: begin
              p_dst = sol;
              p_cnt = LIN_W'(cm);
            end
            default: p_act = A_DONE;
          endcase
        end
      end
      CMD_INS: begin
        if (phase == 2'd0) begin
          p_act = A_WALK;
          p_wk  = W_COPY;
          p_up  = 1'b0;
          p_dst = last_lin;
          p_src = last_lin - LIN_W'(1);
          p_cnt = span;
        end else if (phase == 2'd1) begin
          p_act = A_WALK;
        end
      end
      CMD_DEL: begin
        if (phase == 2'd0) begin
          p_act = A_WALK;
          p_wk  = W_COPY;
          p_src = cur_lin + LIN_W'(1);
          p_cnt = span;
        end else if (phase == 2'd1) begin
          p_act = A_WALK;
          p_dst = last_lin;
        end
      end
      CMD_READ: begin
        if (phase == 2'd0) begin
          p_act = A_WALK;
          p_wk  = W_READ;
          p_src = LIN_W'(idx_q);
        end
      end
      default: p_act = A_DONE;
    endcase
  end

  // memory
  assign mem_we = (st == S_WALK && wk == W_FILL) || (st == S_CPW && wk == W_COPY);
  assign mem_wd = (wk == W_FILL) ? wdata : rdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[dst[AW-1:0]] <= mem_wd;
    rdata <= mem[src[AW-1:0]];
  end

  assign in_ready  = (st == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      out_valid <= 1'b0;
      cur_col  <= '0;
      cur_row  <= '0;
      phase    <= '0;
      scr      <= '0;
      res_sel  <= 2'd0;
      pix_dbl  <= 1'b0;
      brd_en   <= 1'b1;
      brd_w    <= 8'd32;
      brd_h    <= 8'd16;
      fg       <= 4'd15;
      bg       <= 4'd4;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_RES:    res_sel <= cfg_data[1:0];
          REG_DOUBLE: pix_dbl <= cfg_data[0];
          REG_BORDER: brd_en  <= cfg_data[0];
          REG_BW:     brd_w   <= cfg_data;
          REG_BH:     brd_h   <= cfg_data;
          REG_FG:     fg      <= cfg_data[3:0];
          REG_BG:     bg      <= cfg_data[3:0];
          default: ;
        endcase
      end

      // the done state loads the next result itself
      if (out_valid && out_ready && st != S_DONE) out_valid <= 1'b0;

      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q    <= command;
            ch_q     <= char_code;
            px_q     <= pos_x;
            py_q     <= pos_y;
            mode_q   <= clear_mode;
            idx_q    <= cell_index;
            phase    <= '0;
            scr      <= '0;
            scrolled <= 1'b0;
            rd_char  <= '0;
            rd_color <= '0;
            st       <= S_MUL;
          end
        end
        S_MUL: begin
          sol <= LIN_W'(cur_row) * LIN_W'(cm);
          st  <= S_PLAN;
        end
        S_PLAN: begin
          unique case (p_act)
            A_PLACE: begin
              cur_col <= nx;
              cur_row <= ny;
              if (nscroll) begin
                scrolled <= 1'b1;
                scr      <= 2'd1;
                st       <= S_SMUL;
              end else begin
                phase <= phase + 2'd1;
                st    <= S_MUL;
              end
            end
            A_WALK: begin
              wk    <= p_wk;
              up    <= p_up;
              dst   <= p_dst;
              src   <= p_src;
              cnt   <= p_cnt;
              wdata <= p_wd;
              st    <= S_WRAP;
            end
            default: st <= S_DONE;
          endcase
        end
        S_SMUL: begin
          sprod <= LIN_W'(vr - 8'd1) * LIN_W'(cm);
          st    <= S_SLAUNCH;
        end
        S_SLAUNCH: begin
          wk  <= W_COPY;
          up  <= 1'b1;
          dst <= '0;
          src <= LIN_W'(cm);
          cnt <= sprod;
          st  <= S_WRAP;
        end
        S_WRAP: begin
          // reduce both addresses modulo the store size
          if (dst >= CC) dst <= dst - CC;
          if (src >= CC) src <= src - CC;
          if (dst < CC && src < CC) st <= (cnt == '0) ? S_POST : S_WALK;
        end
        S_WALK: begin
          if (wk == W_FILL) begin
            dst <= step(dst, up);
            cnt <= cnt - LIN_W'(1);
            if (cnt == LIN_W'(1)) st <= S_POST;
          end else begin
            st <= S_CPW;
          end
        end
        S_CPW: begin
          if (wk == W_READ) begin
            rd_char  <= rdata[15:8];
            rd_color <= rdata[7:0];
            st       <= S_POST;
          end else begin
            dst <= step(dst, up);
            src <= step(src, up);
            cnt <= cnt - LIN_W'(1);
            st  <= (cnt == LIN_W'(1)) ? S_POST : S_WALK;
          end
        end
        S_POST: begin
          if (scr == 2'd1) begin
            // scroll copy done: blank the last visible row
            wk    <= W_FILL;
            up    <= 1'b1;
            dst   <= sprod;
            src   <= sprod;
            cnt   <= LIN_W'(cm);
            wdata <= {CH_BLANK, color};
            scr   <= 2'd2;
            st    <= S_WRAP;
          end else begin
            scr   <= '0;
            phase <= phase + 2'd1;
            st    <= S_MUL;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            o_col     <= cur_col;
            o_row     <= cur_row;
            o_char    <= rd_char;
            o_color   <= rd_color;
            o_scr     <= scrolled;
            st        <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign cursor_col = o_col;
  assign cursor_row = o_row;
  assign cell_char  = o_char;
  assign cell_color = o_color;
  assign did_scroll = o_scr;

endmodule

/* sv/tcw_checker.sv */
// Port-level checks for the console writer and their attachment to the top level.
module tcw_port_checks (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] cursor_col,
  input logic [6:0] cursor_row,
  input logic [7:0] cell_char
);

  // a result shows nothing in the cycle after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // one command in flight: input closes after a transaction
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second command taken while busy");

  // cursor never reaches beyond the tallest screen
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cursor_row < 7'd96))
    else $error("cursor row out of range");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(cursor_col) && $stable(cell_char)))
    else $error("stalled result changed");

endmodule

bind text_console_cell_writer tcw_port_checks u_tcw_port_checks (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .cursor_col (cursor_col),
  .cursor_row (cursor_row),
  .cell_char  (cell_char)
);

/* test/tcw_checker.sv */
// Checker for the console writer: predicts each result and compares the output channel.
module tcw_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  command,
  input  logic [7:0]  char_code,
  input  logic [6:0]  pos_x,
  input  logic [6:0]  pos_y,
  input  logic [1:0]  clear_mode,
  input  logic [13:0] cell_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [6:0]  cursor_col,
  input  logic [6:0]  cursor_row,
  input  logic [7:0]  cell_char,
  input  logic [7:0]  cell_color,
  input  logic        did_scroll,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fails,
  output int          pending
);
  import tcw_pkg::*;

  localparam int CELLS = 16384;

  typedef struct packed {
    logic [6:0] col;
    logic [6:0] row;
    logic [7:0] ch;
    logic [7:0] color;
    logic       scrolled;
  } cursor_result_t;

  cursor_result_t results_q[$];

  logic [7:0] chars [0:CELLS-1];
  logic [7:0] colors[0:CELLS-1];
  logic [6:0] col_r, row_r;
  logic [1:0] res_r;
  logic       dbl_r, ben_r;
  logic [7:0] bw_r, bh_r;
  logic [3:0] fg_r, bg_r;

  function automatic int unsigned line_pitch();
    int unsigned c;
    case (res_r)
      2'd1: c = 100;
      2'd2: c = 128;
      default: c = 80;
    endcase
    return dbl_r ? c / 2 : c;
  endfunction

  function automatic int unsigned row_span();
    int unsigned r;
    case (res_r)
      2'd0: r = 60;
      2'd1: r = 75;
      2'd2: r = 96;
      default: r = 50;
    endcase
    return dbl_r ? r / 2 : r;
  endfunction

  function automatic int unsigned shown(int unsigned full, int unsigned px);
    int unsigned red;
    red = 0;
    if (ben_r) begin
      red = px / 4;
      if (dbl_r) red = red / 2;
    end
    return (full > red + 1) ? full - red : 1;
  endfunction

  function automatic void blank(int unsigned i);
    chars[i % CELLS]  = CH_BLANK;
    colors[i % CELLS] = {fg_r, bg_r};
  endfunction

  function automatic void move_cell(int unsigned dst, int unsigned src);
    chars[dst % CELLS]  = chars[src % CELLS];
    colors[dst % CELLS] = colors[src % CELLS];
  endfunction

  function automatic bit place(int unsigned x, int unsigned y);
    int unsigned vr, cm;
    bit s;
    vr = shown(row_span(), bh_r);
    cm = line_pitch();
    s = 0;
    if (x >= shown(line_pitch(), bw_r)) begin
      x = 0;
      y++;
    end
    if (y >= vr) begin
      y = vr - 1;
      for (int unsigned r = 0; r + 1 < vr; r++)
        for (int unsigned c = 0; c < cm; c++) move_cell(r * cm + c, (r + 1) * cm + c);
      for (int unsigned c = 0; c < cm; c++) blank((vr - 1) * cm + c);
      s = 1;
    end
    col_r = x[6:0];
    row_r = y[6:0];
    return s;
  endfunction

  function automatic cursor_result_t predict_command(logic [2:0] cmd, logic [7:0] ch,
      logic [6:0] px, logic [6:0] py, logic [1:0] mode, logic [13:0] idx);
    cursor_result_t res;
    int unsigned cm, sol, last, cur;
    cm   = line_pitch();
    sol  = row_r * cm;
    last = sol + cm - 1;
    cur  = sol + col_r;
    res  = '0;
    case (cmd)
      CMD_PUT: begin
        if (ch == CH_LF) res.scrolled = place(0, row_r + 1);
        else if (ch == CH_CR) ;
        else if (ch == CH_BS) begin
          if (col_r > 0) begin
            res.scrolled = place(col_r - 1, row_r);
            blank(row_r * cm + col_r);
          end
        end else if (ch == CH_TAB) res.scrolled = place(col_r + 8, row_r);
        else begin
          chars[cur % CELLS]  = ch;
          colors[cur % CELLS] = {fg_r, bg_r};
          res.scrolled = place(col_r + 1, row_r);
        end
      end
      CMD_SET: res.scrolled = place(px, py);
      CMD_CLS: for (int unsigned i = 0; i < CELLS; i++) blank(i);
      CMD_CLL: begin
        if (mode == CLR_TO_END) for (int unsigned i = cur; i <= last; i++) blank(i);
        else if (mode == CLR_TO_CUR) for (int unsigned i = sol; i <= cur; i++) blank(i);
        else if (mode == CLR_WHOLE) for (int unsigned i = sol; i <= last; i++) blank(i);
      end
      CMD_INS: begin
        for (int unsigned i = last; i > cur; i--) move_cell(i, i - 1);
        blank(cur);
      end
      CMD_DEL: begin
        for (int unsigned i = cur; i < last; i++) move_cell(i, i + 1);
        blank(last);
      end
      CMD_READ: begin
        res.ch    = chars[idx];
        res.color = colors[idx];
      end
      default: ;
    endcase
    res.col = col_r;
    res.row = row_r;
    return res;
  endfunction

  always @(posedge clk) begin
    cursor_result_t exp_r;
    if (rst) begin
      col_r <= '0;
      row_r <= '0;
      res_r <= 2'd0;
      dbl_r <= 1'b0;
      ben_r <= 1'b1;
      bw_r  <= 8'd32;
      bh_r  <= 8'd16;
      fg_r  <= 4'd15;
      bg_r  <= 4'd4;
    end else begin
      // retire before predicting: a result never belongs to the transaction of this edge
      if (out_valid && out_ready) begin
        if (results_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result col=%0d row=%0d", cursor_col, cursor_row);
        end else begin
          exp_r = results_q.pop_front();
          if (exp_r != {cursor_col, cursor_row, cell_char, cell_color, did_scroll}) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch exp col=%0d row=%0d ch=%h clr=%h scr=%b",
                       exp_r.col, exp_r.row, exp_r.ch, exp_r.color, exp_r.scrolled);
              $display("         got col=%0d row=%0d ch=%h clr=%h scr=%b",
                       cursor_col, cursor_row, cell_char, cell_color, did_scroll);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RES:    res_r = cfg_data[1:0];
          REG_DOUBLE: dbl_r = cfg_data[0];
          REG_BORDER: ben_r = cfg_data[0];
          REG_BW:     bw_r  = cfg_data;
          REG_BH:     bh_r  = cfg_data;
          REG_FG:     fg_r  = cfg_data[3:0];
          REG_BG:     bg_r  = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        results_q.push_back(predict_command(command, char_code, pos_x, pos_y, clear_mode,
                                            cell_index));
    end
    pending = results_q.size();
  end

  initial begin
    fails = 0;
    pending = 0;
    for (int i = 0; i < CELLS; i++) begin
      chars[i] = '0;
      colors[i] = '0;
    end
  end

endmodule

/* test/tb_top.sv */
// Testbench top for the console writer: stimulus, receiver stalls and the verdict.
module tb_top;
  import tcw_pkg::*;

  localparam logic [2:0] CMD_NONE = 3'd7;

  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [2:0]  command;
  logic [7:0]  char_code;
  logic [6:0]  pos_x, pos_y;
  logic [1:0]  clear_mode;
  logic [13:0] cell_index;
  logic [6:0]  cursor_col, cursor_row;
  logic [7:0]  cell_char, cell_color;
  logic        did_scroll;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;
  int          fails, pending;
  int          send_idle, recv_idle;
  logic        hold_toggle, hold_seen;
  int          hold_left;

  text_console_cell_writer uut (.*);

  tcw_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (int'($urandom_range(99)) >= recv_idle);
    end
  end

  task automatic send(logic [2:0] cmd, logic [7:0] ch, logic [6:0] px, logic [6:0] py,
                      logic [1:0] mode, logic [13:0] idx);
    while (int'($urandom_range(99)) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    char_code  <= ch;
    pos_x      <= px;
    pos_y      <= py;
    clear_mode <= mode;
    cell_index <= idx;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(logic [1:0] res, logic dbl, logic ben, logic [7:0] bw, logic [7:0] bh,
                       logic [3:0] fg, logic [3:0] bg);
    write_reg(REG_RES, {6'd0, res});
    write_reg(REG_DOUBLE, {7'd0, dbl});
    write_reg(REG_BORDER, {7'd0, ben});
    write_reg(REG_BW, bw);
    write_reg(REG_BH, bh);
    write_reg(REG_FG, {4'd0, fg});
    write_reg(REG_BG, {4'd0, bg});
  endtask

  task automatic random_command(bit allow_cls);
    int pick;
    logic [7:0] ch;
    logic [6:0] px, py;
    logic [1:0] mode;
    logic [13:0] idx;
    pick = int'($urandom_range(999));
    ch = 8'($urandom_range(255));
    px = 7'($urandom_range(127));
    py = 7'($urandom_range(127));
    mode = 2'($urandom_range(3));
    idx = 14'($urandom_range(16383));
    if ($urandom_range(3) == 0) begin
      px = 7'($urandom_range(20));
      py = 7'($urandom_range(20));
    end
    if (pick < 400) begin
      if (ch == CH_LF || ch == CH_BS || ch == CH_TAB || ch == CH_CR) ch = 8'h41;
    end else if (pick < 470) ch = CH_LF;
    else if (pick < 530) ch = CH_BS;
    else if (pick < 590) ch = CH_TAB;
    else if (pick < 620) ch = CH_CR;
    if (pick < 620) send(CMD_PUT, ch, px, py, mode, idx);
    else if (pick < 720) send(CMD_SET, ch, px, py, mode, idx);
    else if (pick < 790) send(CMD_CLL, ch, px, py, mode, idx);
    else if (pick < 855) send(CMD_INS, ch, px, py, mode, idx);
    else if (pick < 920) send(CMD_DEL, ch, px, py, mode, idx);
    else if (pick < 990) send(CMD_READ, ch, px, py, mode, idx);
    else if (pick < 998 || !allow_cls) send(CMD_NONE, ch, px, py, mode, idx);
    else send(CMD_CLS, ch, px, py, mode, idx);
  endtask

  task automatic run_phase(int n, int s_idle, int r_idle, bit allow_cls);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 && n > 100) hold_toggle <= ~hold_toggle;
      random_command(allow_cls);
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cfg_valid = 1'b0;
    command = CMD_PUT;
    char_code = '0;
    pos_x = '0;
    pos_y = '0;
    clear_mode = CLR_TO_END;
    cell_index = '0;
    cfg_index = REG_RES;
    cfg_data = '0;
    hold_toggle = 1'b0;
    send_idle = 27;
    recv_idle = 58;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // define the whole store before anything reads or shifts it
    send(CMD_CLS, 8'd0, 7'd0, 7'd0, CLR_TO_END, 14'd0);
    send(CMD_PUT, 8'd0, 7'd0, 7'd0, CLR_TO_END, 14'd0);
    send(CMD_PUT, 8'd255, 7'd127, 7'd127, CLR_WHOLE, 14'd16383);
    send(CMD_PUT, CH_BS, 7'd0, 7'd0, CLR_TO_END, 14'd0);
    send(CMD_PUT, CH_TAB, 7'd0, 7'd0, CLR_TO_END, 14'd0);
    send(CMD_PUT, CH_CR, 7'd0, 7'd0, CLR_TO_END, 14'd0);
    send(CMD_PUT, CH_LF, 7'd0, 7'd0, CLR_TO_END, 14'd0);
    send(CMD_SET, 8'd0, 7'd0, 7'd0, CLR_TO_END, 14'd0);
    send(CMD_PUT, CH_BS, 7'd0, 7'd0, CLR_TO_END, 14'd0);
    send(CMD_SET, 8'd0, 7'd127, 7'd127, CLR_TO_END, 14'd0);
    send(CMD_SET, 8'd0, 7'd75, 7'd3, CLR_TO_END, 14'd0);
    send(CMD_PUT, 8'h7e, 7'd0, 7'd0, CLR_TO_END, 14'd0);
    send(CMD_SET, 8'd0, 7'd10, 7'd55, CLR_TO_END, 14'd0);
    send(CMD_PUT, CH_LF, 7'd0, 7'd0, CLR_TO_END, 14'd0);
    send(CMD_SET, 8'd0, 7'd5, 7'd2, CLR_TO_END, 14'd0);
    send(CMD_CLL, 8'd0, 7'd0, 7'd0, CLR_TO_END, 14'd0);
    send(CMD_CLL, 8'd0, 7'd0, 7'd0, CLR_TO_CUR, 14'd0);
    send(CMD_CLL, 8'd0, 7'd0, 7'd0, CLR_WHOLE, 14'd0);
    send(CMD_CLL, 8'd0, 7'd0, 7'd0, CLR_NONE, 14'd0);
    send(CMD_INS, 8'd0, 7'd0, 7'd0, CLR_TO_END, 14'd0);
    send(CMD_DEL, 8'd0, 7'd0, 7'd0, CLR_TO_END, 14'd0);
    send(CMD_READ, 8'd0, 7'd0, 7'd0, CLR_TO_END, 14'd0);
    send(CMD_READ, 8'd0, 7'd0, 7'd0, CLR_TO_END, 14'd16383);
    send(CMD_READ, 8'd0, 7'd0, 7'd0, CLR_TO_END, 14'd165);
    send(CMD_NONE, 8'd0, 7'd0, 7'd0, CLR_TO_END, 14'd0);
    drain();

    setup(2'd0, 1'b0, 1'b1, 8'd255, 8'd255, 4'd0, 4'd15);
    run_phase(400, 27, 58, 1);
    setup(2'd1, 1'b1, 1'b1, 8'd0, 8'd200, 4'd9, 4'd6);
    run_phase(400, 58, 27, 0);
    setup(2'd3, 1'b0, 1'b1, 8'd128, 8'd180, 4'd15, 4'd0);
    run_phase(400, 0, 0, 1);
    setup(2'd2, 1'b1, 1'b1, 8'd40, 8'd255, 4'd5, 4'd10);
    run_phase(350, 0, 0, 0);
    // full-size screen without border: keep it short, scrolls walk most of the store
    setup(2'd2, 1'b0, 1'b0, 8'd255, 8'd0, 4'd15, 4'd0);
    run_phase(30, 0, 0, 0);

    if (fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
